[design/qmn_pkg.sv]
// shared types, constants and term tables for the normalised quaternion product
package qmn_pkg;

  // the largest scaled magnitude sits in [2^29, 2^30)
  localparam int NORM_BITS  = 30;
  localparam int SUMSQ_BITS = 2 * NORM_BITS + 2;
  localparam int ROOT_BITS  = SUMSQ_BITS / 2;

  // hamilton product terms: left index, right index, subtract mask per component
  localparam logic [1:0] TERM_L [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd2, 2'd3, 2'd1},
    '{2'd0, 2'd3, 2'd1, 2'd2}
  };
  localparam logic [1:0] TERM_R [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd2, 2'd1}
  };
  localparam logic [3:0] TERM_SUB [4] = '{4'b1110, 4'b1000, 4'b1000, 4'b1000};

  typedef struct packed {
    logic [3:0][NORM_BITS-1:0] mag;
    logic [3:0]                neg;
    logic                      zero;
  } qmn_item_t;

endpackage

[design/qmn_product.sv]
// input stage: sixteen partial products, then signed sums and magnitudes
module qmn_product #(
  parameter int W  = 16,
  parameter int MW = 2 * W + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [W-1:0]  left_w,
  input  logic signed [W-1:0]  left_x,
  input  logic signed [W-1:0]  left_y,
  input  logic signed [W-1:0]  left_z,
  input  logic signed [W-1:0]  right_w,
  input  logic signed [W-1:0]  right_x,
  input  logic signed [W-1:0]  right_y,
  input  logic signed [W-1:0]  right_z,
  output logic                 p_valid,
  output logic [3:0][MW-1:0]   p_mag,
  output logic [3:0]           p_neg
);
  import qmn_pkg::*;

  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 2;

  logic signed [W-1:0]  lq [4];
  logic signed [W-1:0]  rq [4];
  logic signed [PW-1:0] prod [4][4];
  logic signed [SW-1:0] sum [4];
  logic                 v1;
  logic                 en1;

  assign lq[0] = left_w;
  assign lq[1] = left_x;
  assign lq[2] = left_y;
  assign lq[3] = left_z;
  assign rq[0] = right_w;
  assign rq[1] = right_x;
  assign rq[2] = right_y;
  assign rq[3] = right_z;

  // first stage may fill a bubble while the rest is held
  assign en1      = adv | ~v1;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (adv) p_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 4; i++) begin
        for (int t = 0; t < 4; t++) begin
          prod[i][t] <= PW'(lq[TERM_L[i][t]]) * PW'(rq[TERM_R[i][t]]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum[i] = '0;
      for (int t = 0; t < 4; t++) begin
        if (TERM_SUB[i][t]) sum[i] = sum[i] - SW'(prod[i][t]);
        else                sum[i] = sum[i] + SW'(prod[i][t]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        p_neg[i] <= sum[i][SW-1];
        p_mag[i] <= sum[i][SW-1] ? MW'(-sum[i]) : MW'(sum[i]);
      end
    end
  end

endmodule

[design/qmn_normalise.sv]
// block scaling to [2^29, 2^30), squares and sum of squares
module qmn_normalise #(
  parameter int MW = 33
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          p_valid,
  input  logic [3:0][MW-1:0]            p_mag,
  input  logic [3:0]                    p_neg,
  output logic                          n_valid,
  output qmn_pkg::qmn_item_t            n_item,
  output logic [qmn_pkg::SUMSQ_BITS-1:0] n_sumsq
);
  import qmn_pkg::*;

  localparam int LW = $clog2(MW) + 1;
  localparam int SQ = 2 * NORM_BITS;

  logic [MW-1:0]            orv;
  logic [LW-1:0]            lead;
  logic [3:0][MW-1:0]       mag3;
  logic [3:0]               neg3;
  logic                     zero3;
  logic [LW-1:0]            lead3;
  logic [LW:0]              shamt;
  logic [MW+NORM_BITS-1:0]  ext [4];
  qmn_item_t                item4, item5;
  logic [3:0][SQ-1:0]       sq5;
  logic [3:0]               v;

  assign orv = p_mag[0] | p_mag[1] | p_mag[2] | p_mag[3];

  always_comb begin
    lead = '0;
    for (int j = 0; j < MW; j++) begin
      if (orv[j]) lead = LW'(j);
    end
  end

  // bit lead moves to bit 29; low bits drop when scaling down
  assign shamt = {1'b0, lead3} + (LW+1)'(1);
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ext[i] = {mag3[i], {NORM_BITS{1'b0}}} >> shamt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[2:0], p_valid};
    end
  end
  assign n_valid = v[3];

  always_ff @(posedge clk) begin
    if (adv) begin
      mag3  <= p_mag;
      neg3  <= p_neg;
      zero3 <= (orv == '0);
      lead3 <= lead;
      for (int i = 0; i < 4; i++) begin
        item4.mag[i] <= ext[i][NORM_BITS-1:0];
      end
      item4.neg  <= neg3;
      item4.zero <= zero3;
      for (int i = 0; i < 4; i++) begin
        sq5[i] <= SQ'(item4.mag[i]) * SQ'(item4.mag[i]);
      end
      item5   <= item4;
      n_sumsq <= SUMSQ_BITS'(sq5[0]) + SUMSQ_BITS'(sq5[1])
               + SUMSQ_BITS'(sq5[2]) + SUMSQ_BITS'(sq5[3]);
      n_item  <= item5;
    end
  end

endmodule

[design/qmn_sqrt.sv]
// integer square root, one result bit per pipeline stage
module qmn_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           n_valid,
  input  qmn_pkg::qmn_item_t             n_item,
  input  logic [qmn_pkg::SUMSQ_BITS-1:0] n_sumsq,
  output logic                           r_valid,
  output qmn_pkg::qmn_item_t             r_item,
  output logic [qmn_pkg::ROOT_BITS-1:0]  r_root
);
  import qmn_pkg::*;

  localparam int RB = ROOT_BITS;

  typedef struct packed {
    qmn_item_t               item;
    logic [SUMSQ_BITS-1:0]   s;
    logic [RB:0]             rem;
    logic [RB-1:0]           root;
  } sq_stage_t;

  function automatic sq_stage_t sq_step(sq_stage_t a);
    sq_stage_t       b;
    logic [RB+2:0]   cur;
    logic [RB+2:0]   trial;
    b     = a;
    cur   = {a.rem, a.s[SUMSQ_BITS-1 -: 2]};
    trial = {1'b0, a.root, 2'b01};
    b.s   = {a.s[SUMSQ_BITS-3:0], 2'b00};
    if (cur >= trial) begin
      b.rem  = (RB+1)'(cur - trial);
      b.root = {a.root[RB-2:0], 1'b1};
    end else begin
      b.rem  = (RB+1)'(cur);
      b.root = {a.root[RB-2:0], 1'b0};
    end
    return b;
  endfunction

  sq_stage_t st [RB+1];
  logic      v  [RB+1];

  assign st[0].item = n_item;
  assign st[0].s    = n_sumsq;
  assign st[0].rem  = '0;
  assign st[0].root = '0;
  assign v[0]       = n_valid;

  for (genvar k = 1; k <= RB; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv) begin
        v[k] <= v[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) st[k] <= sq_step(st[k-1]);
    end
  end

  assign r_valid = v[RB];
  assign r_item  = st[RB].item;
  assign r_root  = st[RB].root;

endmodule

[design/qmn_divide.sv]
// restoring division of each scaled component by the root, then sign and output register
module qmn_divide #(
  parameter int W = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          r_valid,
  input  qmn_pkg::qmn_item_t            r_item,
  input  logic [qmn_pkg::ROOT_BITS-1:0] r_root,
  output logic                          out_valid,
  output logic signed [W-1:0]           prod_w,
  output logic signed [W-1:0]           prod_x,
  output logic signed [W-1:0]           prod_y,
  output logic signed [W-1:0]           prod_z,
  output logic                          zero_magnitude
);
  import qmn_pkg::*;

  localparam int QB = W - 1;
  localparam int RB = ROOT_BITS;
  localparam int NW = NORM_BITS + QB + 1;

  typedef struct packed {
    logic [3:0][RB:0]   rem;
    logic [3:0][QB-1:0] nlo;
    logic [3:0][QB-1:0] q;
    logic [RB:0]        d;
    logic [3:0]         neg;
    logic               zero;
  } dv_stage_t;

  function automatic dv_stage_t dv_step(dv_stage_t a);
    dv_stage_t     b;
    logic [RB+1:0] cur;
    b = a;
    for (int i = 0; i < 4; i++) begin
      cur      = {a.rem[i], a.nlo[i][QB-1]};
      b.nlo[i] = {a.nlo[i][QB-2:0], 1'b0};
      if (cur >= {1'b0, a.d}) begin
        b.rem[i] = (RB+1)'(cur - {1'b0, a.d});
        b.q[i]   = {a.q[i][QB-2:0], 1'b1};
      end else begin
        b.rem[i] = (RB+1)'(cur);
        b.q[i]   = {a.q[i][QB-2:0], 1'b0};
      end
    end
    return b;
  endfunction

  dv_stage_t        st [QB+1];
  logic             v  [QB+1];
  logic [NW-1:0]    num [4];
  logic signed [W-1:0] res [4];

  // numerator 2*m*2^F + root, divisor 2*root
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      num[i] = NW'({r_item.mag[i], {(QB){1'b0}}}) + NW'(r_root);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        st[0].rem[i] <= (RB+1)'(num[i] >> QB);
        st[0].nlo[i] <= num[i][QB-1:0];
      end
      st[0].q    <= '0;
      st[0].d    <= {r_root, 1'b0};
      st[0].neg  <= r_item.neg;
      st[0].zero <= r_item.zero;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv) begin
        v[k] <= v[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) st[k] <= dv_step(st[k-1]);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (st[QB].zero) res[i] = '0;
      else if (st[QB].neg[i]) res[i] = -W'(st[QB].q[i]);
      else res[i] = W'(st[QB].q[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_w         <= res[0];
      prod_x         <= res[1];
      prod_y         <= res[2];
      prod_z         <= res[3];
      zero_magnitude <= st[QB].zero;
    end
  end

endmodule

[design/quaternion_multiply_normalize.sv]
// top level: normalised hamilton product of two quaternions, fixed point
// throughput one transfer per cycle while the pipe is not stalled by a held result;
// the longest part is the 31-stage root pipeline
// followed by COMP_WIDTH-1 divide stages, one quotient bit per stage
// reset (rst, synchronous) clears only the valid bits; data needs no reset
// a held result stalls the pipe, the first stage still fills while empty
module quaternion_multiply_normalize #(
  parameter int COMP_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COMP_WIDTH-1:0]  left_w,
  input  logic signed [COMP_WIDTH-1:0]  left_x,
  input  logic signed [COMP_WIDTH-1:0]  left_y,
  input  logic signed [COMP_WIDTH-1:0]  left_z,
  input  logic signed [COMP_WIDTH-1:0]  right_w,
  input  logic signed [COMP_WIDTH-1:0]  right_x,
  input  logic signed [COMP_WIDTH-1:0]  right_y,
  input  logic signed [COMP_WIDTH-1:0]  right_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COMP_WIDTH-1:0]  prod_w,
  output logic signed [COMP_WIDTH-1:0]  prod_x,
  output logic signed [COMP_WIDTH-1:0]  prod_y,
  output logic signed [COMP_WIDTH-1:0]  prod_z,
  output logic                          zero_magnitude
);
  import qmn_pkg::*;

  // magnitude of a sum of four full products
  localparam int MW = 2 * COMP_WIDTH + 1;

  logic                    adv;
  logic                    p_valid;
  logic [3:0][MW-1:0]      p_mag;
  logic [3:0]              p_neg;
  logic                    n_valid;
  qmn_item_t               n_item;
  logic [SUMSQ_BITS-1:0]   n_sumsq;
  logic                    r_valid;
  qmn_item_t               r_item;
  logic [ROOT_BITS-1:0]    r_root;

  // whole pipe moves when the output register is free or being taken
  assign adv = ~out_valid | out_ready;

  // stages 1-2: partial products, signed sums
  qmn_product #(.W(COMP_WIDTH), .MW(MW)) u_product (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .left_w   (left_w),
    .left_x   (left_x),
    .left_y   (left_y),
    .left_z   (left_z),
    .right_w  (right_w),
    .right_x  (right_x),
    .right_y  (right_y),
    .right_z  (right_z),
    .p_valid  (p_valid),
    .p_mag    (p_mag),
    .p_neg    (p_neg)
  );

  // stages 3-6: leading-one search, common shift, squares, sum
  qmn_normalise #(.MW(MW)) u_normalise (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .p_valid (p_valid),
    .p_mag   (p_mag),
    .p_neg   (p_neg),
    .n_valid (n_valid),
    .n_item  (n_item),
    .n_sumsq (n_sumsq)
  );

  // 31 stages: floor square root of the sum of squares
  qmn_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .n_valid (n_valid),
    .n_item  (n_item),
    .n_sumsq (n_sumsq),
    .r_valid (r_valid),
    .r_item  (r_item),
    .r_root  (r_root)
  );

  // setup stage, one stage per quotient bit, output register
  // zero product: root is zero, quotient is ignored and outputs forced to zero
  qmn_divide #(.W(COMP_WIDTH)) u_divide (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .r_valid        (r_valid),
    .r_item         (r_item),
    .r_root         (r_root),
    .out_valid      (out_valid),
    .prod_w         (prod_w),
    .prod_x         (prod_x),
    .prod_y         (prod_y),
    .prod_z         (prod_z),
    .zero_magnitude (zero_magnitude)
  );

endmodule

[design/qmn_checker.sv]
// port-level checks for the normalised quaternion product, bound to the top level
module qmn_checker #(
  parameter int W = 16
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [W-1:0]  prod_w,
  input logic signed [W-1:0]  prod_x,
  input logic signed [W-1:0]  prod_y,
  input logic signed [W-1:0]  prod_z,
  input logic                 zero_magnitude
);
  localparam logic signed [W-1:0] ONE = W'(1) <<< (W - 2);

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(prod_w) && $stable(prod_x)
      && $stable(prod_y) && $stable(prod_z) && $stable(zero_magnitude))
    else $error("result changed while held");

  // nothing comes out in the cycle after a reset cycle
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  // an offered transfer is never refused while no result waits
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_valid |-> in_ready)
    else $error("input refused with no result waiting");

  // zero product gives all-zero components
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_magnitude |->
      prod_w == '0 && prod_x == '0 && prod_y == '0 && prod_z == '0)
    else $error("zero product with nonzero components");

  // a unit quaternion has a nonzero component, each within plus or minus one
  a_unit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !zero_magnitude |->
      (prod_w != '0 || prod_x != '0 || prod_y != '0 || prod_z != '0)
      && prod_w <= ONE && prod_w >= -ONE && prod_x <= ONE && prod_x >= -ONE
      && prod_y <= ONE && prod_y >= -ONE && prod_z <= ONE && prod_z >= -ONE)
    else $error("normalised result out of range");

endmodule

bind quaternion_multiply_normalize qmn_checker #(.W(COMP_WIDTH)) u_qmn_checker (.*);
